>>> src/q4sd_pkg.sv
// Package for the bilinear quad shape function derivative pipeline: widths, types, rounding.
`default_nettype none
package q4sd_pkg;

    localparam int NatW       = 18;
    localparam int CoordW     = 32;
    localparam int DiffW      = CoordW + 1;
    localparam int ShpW       = NatW + 1;
    localparam int ProdW      = DiffW + ShpW;
    localparam int SumW       = ProdW + 1;
    localparam int JacW       = 32;
    localparam int JacRoundSh = 18;
    localparam int JacSW      = SumW - JacRoundSh + 1;
    localparam int DetW       = 2 * JacW;
    localparam int NumPW      = ShpW + JacW;
    localparam int NumW       = NumPW + 1;
    localparam int MagW       = NumW;
    localparam int FracSh     = 14;
    localparam int RemW       = MagW + FracSh;
    localparam int DenW       = DetW;
    localparam int QW         = 32;
    localparam int WideW      = DenW + QW + 1;
    localparam int OutW       = QW;
    localparam int DetOutW    = 48;
    localparam int DetRoundSh = 16;
    localparam int Lanes      = 8;
    localparam int JacSt      = 3;
    localparam int DetSt      = 3;
    localparam int DivSt      = QW + 3;
    localparam int NumSt      = JacSt + DetSt + DivSt;

    localparam logic signed [ShpW-1:0] One    = ShpW'(65536);
    localparam logic signed [JacW-1:0] JacMax = {1'b0, {(JacW-1){1'b1}}};

    typedef struct packed {
        logic signed [ShpW-1:0] ome;
        logic signed [ShpW-1:0] ope;
        logic signed [ShpW-1:0] omx;
        logic signed [ShpW-1:0] opx;
    } t_shp;

    typedef struct packed {
        logic signed [JacW-1:0] j00;
        logic signed [JacW-1:0] j01;
        logic signed [JacW-1:0] j10;
        logic signed [JacW-1:0] j11;
        t_shp                   shp;
    } t_jac;

    typedef struct packed {
        logic [DenW-1:0]             den;
        logic [Lanes-1:0][MagW-1:0]  mag;
        logic [Lanes-1:0]            neg;
        logic [DetOutW-1:0]          det_out;
        logic                        degen;
    } t_div_in;

    // quarter of a Q.32 sum to Q16.16, round half up, symmetric saturation
    function automatic logic signed [JacW-1:0] jac_round(input logic signed [SumW-1:0] raw);
        logic signed [SumW:0]    t;
        logic signed [SumW:0]    half;
        logic signed [JacSW-1:0] s;
        logic signed [JacSW-1:0] hi;
        logic signed [JacSW-1:0] lo;
        half = {{(SumW-JacRoundSh+1){1'b0}}, 1'b1, {(JacRoundSh-1){1'b0}}};
        t    = $signed({raw[SumW-1], raw}) + half;
        s    = $signed(t[SumW:JacRoundSh]);
        hi   = {{(JacSW-JacW){1'b0}}, JacMax};
        lo   = -hi;
        if (s > hi) begin
            return JacMax;
        end else if (s < lo) begin
            return -JacMax;
        end
        return $signed(s[JacW-1:0]);
    endfunction

endpackage
`default_nettype wire

>>> src/quad4_shape_derivatives.sv
// Top level: bilinear quad shape function x/y derivatives and Jacobian determinant.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------------
//  input   | i_valid | o_ready | i_xi_coord, i_eta_coord, i_node1_x .. i_node4_y
//  output  | o_valid | i_ready | o_dn1_dx .. o_dn4_dy, o_jacobian_det, o_degenerate
//
// One item per cycle while i_ready does not stall the output, 41 register stages.
// Depth is set by the 32-stage bit-per-stage quotient pipeline (plus 9 other stages).
// Each stage advances when it is empty or the next one advances; bubbles collapse.
// Reset clears only the stage valid bits.
`default_nettype none
module quad4_shape_derivatives (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [q4sd_pkg::NatW-1:0]    i_xi_coord,
    input  logic signed [q4sd_pkg::NatW-1:0]    i_eta_coord,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node1_x,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node1_y,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node2_x,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node2_y,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node3_x,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node3_y,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node4_x,
    input  logic signed [q4sd_pkg::CoordW-1:0]  i_node4_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn1_dx,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn2_dx,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn3_dx,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn4_dx,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn1_dy,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn2_dy,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn3_dy,
    output logic signed [q4sd_pkg::OutW-1:0]    o_dn4_dy,
    output logic signed [q4sd_pkg::DetOutW-1:0] o_jacobian_det,
    output logic                                o_degenerate
);
    import q4sd_pkg::*;

    logic [NumSt-1:0]             r_vld;
    logic [NumSt-1:0]             en;
    logic signed [CoordW-1:0]     px [4];
    logic signed [CoordW-1:0]     py [4];
    t_jac                         jac;
    t_div_in                      dvin;
    logic [Lanes-1:0][OutW-1:0]   deriv;
    logic [DetOutW-1:0]           det_out;

    always_comb begin
        en[NumSt-1] = !r_vld[NumSt-1] || i_ready;
        for (int k = NumSt - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NumSt; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NumSt-1];

    assign px[0] = i_node1_x;
    assign px[1] = i_node2_x;
    assign px[2] = i_node3_x;
    assign px[3] = i_node4_x;
    assign py[0] = i_node1_y;
    assign py[1] = i_node2_y;
    assign py[2] = i_node3_y;
    assign py[3] = i_node4_y;

    q4sd_jac u_jac (
        .i_clk (i_clk),
        .i_en  (en[JacSt-1:0]),
        .i_xi  (i_xi_coord),
        .i_eta (i_eta_coord),
        .i_px  (px),
        .i_py  (py),
        .o_jac (jac)
    );

    q4sd_det u_det (
        .i_clk (i_clk),
        .i_en  (en[JacSt+DetSt-1:JacSt]),
        .i_jac (jac),
        .o_div (dvin)
    );

    q4sd_div u_div (
        .i_clk   (i_clk),
        .i_en    (en[NumSt-1:JacSt+DetSt]),
        .i_div   (dvin),
        .o_deriv (deriv),
        .o_det   (det_out),
        .o_degen (o_degenerate)
    );

    assign o_dn1_dx       = $signed(deriv[0]);
    assign o_dn2_dx       = $signed(deriv[1]);
    assign o_dn3_dx       = $signed(deriv[2]);
    assign o_dn4_dx       = $signed(deriv[3]);
    assign o_dn1_dy       = $signed(deriv[4]);
    assign o_dn2_dy       = $signed(deriv[5]);
    assign o_dn3_dy       = $signed(deriv[6]);
    assign o_dn4_dy       = $signed(deriv[7]);
    assign o_jacobian_det = $signed(det_out);

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_dn1_dx == '0 && o_dn2_dx == '0 && o_dn3_dx == '0 &&
            o_dn4_dx == '0 && o_dn1_dy == '0 && o_dn2_dy == '0 && o_dn3_dy == '0 &&
            o_dn4_dy == '0)
        else $error("degenerate item with nonzero derivative");

    a_degen_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_jacobian_det == '0)
        else $error("degenerate item with nonzero determinant");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item not captured in first stage");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_jacobian_det))
        else $error("stalled result dropped");

endmodule
`default_nettype wire

>>> src/q4sd_jac.sv
// Jacobian stages: corner differences, shape terms, products, rounded entries.
`default_nettype none
module q4sd_jac (
    input  logic                                  i_clk,
    input  logic [q4sd_pkg::JacSt-1:0]            i_en,
    input  logic signed [q4sd_pkg::NatW-1:0]      i_xi,
    input  logic signed [q4sd_pkg::NatW-1:0]      i_eta,
    input  logic signed [q4sd_pkg::CoordW-1:0]    i_px [4],
    input  logic signed [q4sd_pkg::CoordW-1:0]    i_py [4],
    output q4sd_pkg::t_jac                        o_jac
);
    import q4sd_pkg::*;

    t_shp                    r_shp0, r_shp1;
    logic signed [DiffW-1:0] r_d [8];
    logic signed [ProdW-1:0] r_p [8];

    // x2-x1, x3-x4, x4-x1, x3-x2, then the same for y
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_shp0.ome <= One - ShpW'(i_eta);
            r_shp0.ope <= One + ShpW'(i_eta);
            r_shp0.omx <= One - ShpW'(i_xi);
            r_shp0.opx <= One + ShpW'(i_xi);
            r_d[0] <= DiffW'(i_px[1]) - DiffW'(i_px[0]);
            r_d[1] <= DiffW'(i_px[2]) - DiffW'(i_px[3]);
            r_d[2] <= DiffW'(i_px[3]) - DiffW'(i_px[0]);
            r_d[3] <= DiffW'(i_px[2]) - DiffW'(i_px[1]);
            r_d[4] <= DiffW'(i_py[1]) - DiffW'(i_py[0]);
            r_d[5] <= DiffW'(i_py[2]) - DiffW'(i_py[3]);
            r_d[6] <= DiffW'(i_py[3]) - DiffW'(i_py[0]);
            r_d[7] <= DiffW'(i_py[2]) - DiffW'(i_py[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_shp1 <= r_shp0;
            r_p[0] <= ProdW'(r_shp0.ome) * ProdW'(r_d[0]);
            r_p[1] <= ProdW'(r_shp0.ope) * ProdW'(r_d[1]);
            r_p[2] <= ProdW'(r_shp0.omx) * ProdW'(r_d[2]);
            r_p[3] <= ProdW'(r_shp0.opx) * ProdW'(r_d[3]);
            r_p[4] <= ProdW'(r_shp0.ome) * ProdW'(r_d[4]);
            r_p[5] <= ProdW'(r_shp0.ope) * ProdW'(r_d[5]);
            r_p[6] <= ProdW'(r_shp0.omx) * ProdW'(r_d[6]);
            r_p[7] <= ProdW'(r_shp0.opx) * ProdW'(r_d[7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_jac.shp <= r_shp1;
            o_jac.j00 <= jac_round(SumW'(r_p[0]) + SumW'(r_p[1]));
            o_jac.j01 <= jac_round(SumW'(r_p[2]) + SumW'(r_p[3]));
            o_jac.j10 <= jac_round(SumW'(r_p[4]) + SumW'(r_p[5]));
            o_jac.j11 <= jac_round(SumW'(r_p[6]) + SumW'(r_p[7]));
        end
    end

endmodule
`default_nettype wire

>>> src/q4sd_det.sv
// Determinant and adjugate numerator stages, magnitudes and signs for the dividers.
`default_nettype none
module q4sd_det (
    input  logic                        i_clk,
    input  logic [q4sd_pkg::DetSt-1:0]  i_en,
    input  q4sd_pkg::t_jac              i_jac,
    output q4sd_pkg::t_div_in           o_div
);
    import q4sd_pkg::*;

    logic signed [DetW-1:0]  r_pa, r_pb, r_det;
    logic signed [NumPW-1:0] r_np [8];
    logic signed [NumW-1:0]  r_num [Lanes];
    logic signed [DetW:0]    det_rnd;
    logic signed [DetW:0]    det_half;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pa    <= DetW'(i_jac.j00) * DetW'(i_jac.j11);
            r_pb    <= DetW'(i_jac.j01) * DetW'(i_jac.j10);
            r_np[0] <= NumPW'(i_jac.shp.ome) * NumPW'(i_jac.j11);
            r_np[1] <= NumPW'(i_jac.shp.ope) * NumPW'(i_jac.j11);
            r_np[2] <= NumPW'(i_jac.shp.omx) * NumPW'(i_jac.j10);
            r_np[3] <= NumPW'(i_jac.shp.opx) * NumPW'(i_jac.j10);
            r_np[4] <= NumPW'(i_jac.shp.omx) * NumPW'(i_jac.j00);
            r_np[5] <= NumPW'(i_jac.shp.opx) * NumPW'(i_jac.j00);
            r_np[6] <= NumPW'(i_jac.shp.ome) * NumPW'(i_jac.j01);
            r_np[7] <= NumPW'(i_jac.shp.ope) * NumPW'(i_jac.j01);
        end
    end

    // lanes 0..3 are d/dx of N1..N4, lanes 4..7 d/dy
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_det    <= r_pa - r_pb;
            r_num[0] <= NumW'(r_np[2]) - NumW'(r_np[0]);
            r_num[1] <= NumW'(r_np[0]) + NumW'(r_np[3]);
            r_num[2] <= NumW'(r_np[1]) - NumW'(r_np[3]);
            r_num[3] <= -NumW'(r_np[1]) - NumW'(r_np[2]);
            r_num[4] <= NumW'(r_np[6]) - NumW'(r_np[4]);
            r_num[5] <= -NumW'(r_np[5]) - NumW'(r_np[6]);
            r_num[6] <= NumW'(r_np[5]) - NumW'(r_np[7]);
            r_num[7] <= NumW'(r_np[4]) + NumW'(r_np[7]);
        end
    end

    always_comb begin
        det_half = {{(DetW-DetRoundSh+1){1'b0}}, 1'b1, {(DetRoundSh-1){1'b0}}};
        det_rnd  = $signed({r_det[DetW-1], r_det}) + det_half;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_div.den     <= r_det[DetW-1] ? DenW'(-r_det) : DenW'(r_det);
            o_div.det_out <= det_rnd[DetRoundSh+DetOutW-1:DetRoundSh];
            o_div.degen   <= (r_det == '0);
            for (int l = 0; l < Lanes; l++) begin
                o_div.mag[l] <= r_num[l][NumW-1] ? MagW'(-r_num[l]) : MagW'(r_num[l]);
                o_div.neg[l] <= r_num[l][NumW-1] ^ r_det[DetW-1];
            end
        end
    end

endmodule
`default_nettype wire

>>> src/q4sd_div.sv
// Eight pipelined restoring dividers, one quotient bit per stage, with rounding and saturation.
`default_nettype none
module q4sd_div (
    input  logic                                            i_clk,
    input  logic [q4sd_pkg::DivSt-1:0]                      i_en,
    input  q4sd_pkg::t_div_in                               i_div,
    output logic [q4sd_pkg::Lanes-1:0][q4sd_pkg::OutW-1:0]  o_deriv,
    output logic [q4sd_pkg::DetOutW-1:0]                    o_det,
    output logic                                            o_degen
);
    import q4sd_pkg::*;

    localparam logic [QW:0] PosLim = {2'b00, {(QW-1){1'b1}}};
    localparam logic [QW:0] NegLim = {2'b01, {(QW-1){1'b0}}};

    logic [DenW-1:0]    r_den   [QW+1];
    logic [DetOutW-1:0] r_deto  [QW+2];
    logic               r_degen [QW+2];
    logic [Lanes-1:0]   r_neg   [QW+2];
    logic [Lanes-1:0]   r_ovf   [QW+2];
    logic [RemW-1:0]    r_rem   [QW+1][Lanes];
    logic [QW-1:0]      r_q     [QW+1][Lanes];
    logic [QW:0]        r_qr    [Lanes];
    logic [Lanes-1:0]   ovf0;
    logic [Lanes-1:0]   rnd;

    // quotient of 2^32 or more saturates unless the item is degenerate
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            ovf0[l] = WideW'({i_div.mag[l], {FracSh{1'b0}}}) >= (WideW'(i_div.den) << QW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_den[0]   <= i_div.den;
            r_deto[0]  <= i_div.det_out;
            r_degen[0] <= i_div.degen;
            r_neg[0]   <= i_div.neg;
            r_ovf[0]   <= ovf0;
            for (int l = 0; l < Lanes; l++) begin
                r_rem[0][l] <= {i_div.mag[l], {FracSh{1'b0}}};
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_bit
        logic [WideW-1:0] dsh;
        logic [RemW-1:0]  n_rem [Lanes];
        logic [QW-1:0]    n_q   [Lanes];

        always_comb begin
            dsh = WideW'(r_den[s-1]) << (QW - s);
            for (int l = 0; l < Lanes; l++) begin
                n_q[l] = r_q[s-1][l];
                if (WideW'(r_rem[s-1][l]) >= dsh) begin
                    n_rem[l]       = RemW'(WideW'(r_rem[s-1][l]) - dsh);
                    n_q[l][QW - s] = 1'b1;
                end else begin
                    n_rem[l]       = r_rem[s-1][l];
                    n_q[l][QW - s] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_den[s]   <= r_den[s-1];
                r_deto[s]  <= r_deto[s-1];
                r_degen[s] <= r_degen[s-1];
                r_neg[s]   <= r_neg[s-1];
                r_ovf[s]   <= r_ovf[s-1];
                for (int l = 0; l < Lanes; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_q[s][l]   <= n_q[l];
                end
            end
        end
    end

    // round to nearest, ties away from zero
    always_comb begin
        for (int l = 0; l < Lanes; l++) begin
            rnd[l] = ((RemW+1)'(r_rem[QW][l]) << 1) >= (RemW+1)'(r_den[QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+1]) begin
            r_deto[QW+1]  <= r_deto[QW];
            r_degen[QW+1] <= r_degen[QW];
            r_neg[QW+1]   <= r_neg[QW];
            r_ovf[QW+1]   <= r_ovf[QW];
            for (int l = 0; l < Lanes; l++) begin
                r_qr[l] <= (QW+1)'(r_q[QW][l]) + (QW+1)'(rnd[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+2]) begin
            o_det   <= r_deto[QW+1];
            o_degen <= r_degen[QW+1];
            for (int l = 0; l < Lanes; l++) begin
                if (r_degen[QW+1]) begin
                    o_deriv[l] <= '0;
                end else if (r_neg[QW+1][l]) begin
                    o_deriv[l] <= (r_ovf[QW+1][l] || r_qr[l] > NegLim) ?
                                  NegLim[QW-1:0] : -r_qr[l][QW-1:0];
                end else begin
                    o_deriv[l] <= (r_ovf[QW+1][l] || r_qr[l] > PosLim) ?
                                  PosLim[QW-1:0] : r_qr[l][QW-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire
